// ===== hdl/ctrr_pkg.sv =====
package ctrr_pkg;

   localparam int unsigned LEN_W        = 10;
   localparam int unsigned REPORT_BYTES = 64;

   localparam logic [31:0] BCAST_ID     = 32'hFFFF_FFFF;
   localparam logic [7:0]  CMD_INIT     = 8'h86;
   localparam logic [7:0]  CMD_PING     = 8'h81;
   localparam logic [7:0]  CMD_MSG      = 8'h83;
   localparam logic [7:0]  INIT_FLAG    = 8'h80;
   localparam logic [5:0]  INIT_PAYLOAD = 6'd57;
   localparam logic [5:0]  CONT_PAYLOAD = 6'd59;
   localparam logic [2:0]  INIT_BASE    = 3'd7;
   localparam logic [2:0]  CONT_BASE    = 3'd5;

   localparam logic [2:0]  KIND_IGNORED = 3'd0;
   localparam logic [2:0]  KIND_INIT    = 3'd1;
   localparam logic [2:0]  KIND_PING    = 3'd2;
   localparam logic [2:0]  KIND_INVALID = 3'd3;
   localparam logic [2:0]  KIND_FRAG    = 3'd4;
   localparam logic [2:0]  KIND_MESSAGE = 3'd5;

   // Byte i of the report is element i.
   typedef logic [REPORT_BYTES-1:0][7:0] report_type;

   // Byte window of one fragment write: message offsets [start, stop) take
   // report bytes starting at base.
   typedef struct packed {
      logic [LEN_W-1:0] start;
      logic [LEN_W-1:0] stop;
      logic [2:0]       base;
   } win_type;

endpackage

// ===== hdl/ctrr_ram.sv =====
module ctrr_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // The read data holds until the next read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/ctrr_merge.sv =====
module ctrr_merge
   import ctrr_pkg::*;
(
   input  logic [LEN_W-1:0] word_base,
   input  win_type          win,
   input  report_type       report,
   input  logic [63:0]      old_word,
   output logic [63:0]      new_word
);

   logic [LEN_W-1:0] pos [8];
   logic [LEN_W-1:0] src [8];
   logic             hit [8];

   // Each lane takes a report byte when its offset falls inside the window
   // and keeps the stored byte otherwise.
   always_comb begin
      for (int j = 0; j < 8; j++) begin
         pos[j] = word_base + LEN_W'(j);
         hit[j] = (pos[j] >= win.start) && (pos[j] < win.stop);
         src[j] = pos[j] - win.start + LEN_W'(win.base);
         new_word[63-8*j -: 8] = hit[j] ? report[src[j][5:0]] : old_word[63-8*j -: 8];
      end
   end

endmodule

// ===== hdl/ctaphid_report_reassembler_unit.sv =====
// A request is decoded in the cycle after it is taken; a single result is loaded into
// the output register once that register is free. A message fragment touches at most nine
// message words, each read, merged and written back through the store's RMW port. Ping and
// message words leave at one per cycle when the output is not stalled; the store's one read
// port sets the readout rate. Reset clears the state machine, channel and message state, the
// sequencer flags and the output valid; the message store is not cleared and needs no sweep.
module ctaphid_report_reassembler_unit
   import ctrr_pkg::*;
#(
   parameter int unsigned MAX_MESSAGE_BYTES = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_report_word_0,
   input  logic [63:0] req_report_word_1,
   input  logic [63:0] req_report_word_2,
   input  logic [63:0] req_report_word_3,
   input  logic [63:0] req_report_word_4,
   input  logic [63:0] req_report_word_5,
   input  logic [63:0] req_report_word_6,
   input  logic [63:0] req_report_word_7,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [31:0] rsp_channel_id,
   output logic [31:0] rsp_assigned_id,
   output logic [63:0] rsp_nonce,
   output logic [63:0] rsp_data_word,
   output logic [5:0]  rsp_word_index,
   output logic [9:0]  rsp_byte_count,
   output logic        rsp_last
);

   // The message store holds one 64-bit word per eight message bytes.
   localparam int unsigned DEPTH = (MAX_MESSAGE_BYTES + 7) / 8;
   localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [15:0] MAX_LEN = 16'(MAX_MESSAGE_BYTES);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_PING,
      ST_WRITE,
      ST_FRAG,
      ST_READ
   } state_type;

   state_type        state_ff, state_in;
   report_type       rep_ff, rep_in;
   logic [31:0]      next_ch_ff, next_ch_in;
   logic [31:0]      active_ff, active_in;
   logic             assembling_ff, assembling_in;
   logic [31:0]      asm_ch_ff, asm_ch_in;
   logic [LEN_W-1:0] exp_ff, exp_in;
   logic [LEN_W-1:0] recv_ff, recv_in;
   logic [7:0]       seq_ff, seq_in;

   // Fragment write sequencer: reads run one word ahead of the merged write.
   win_type          win_ff, win_in;
   logic [AW-1:0]    wr_rd_ff, wr_rd_in;
   logic [AW-1:0]    wr_stop_ff, wr_stop_in;
   logic             wr_issue_ff, wr_issue_in;
   logic             pend_ff, pend_in;
   logic [AW-1:0]    pend_w_ff, pend_w_in;
   logic             done_read_ff, done_read_in;

   // Readout sequencer.
   logic [AW-1:0]    rd_k_ff, rd_k_in;
   logic             rd_issue_ff, rd_issue_in;
   logic             rd_pend_ff, rd_pend_in;
   logic [AW-1:0]    rd_cur_ff, rd_cur_in;

   // Ping echo.
   logic [2:0]       ping_k_ff, ping_k_in;
   logic [5:0]       ping_cnt_ff, ping_cnt_in;

   // Output register.
   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       rsp_kind_ff, rsp_kind_in;
   logic [31:0]      rsp_ch_ff, rsp_ch_in;
   logic [31:0]      rsp_asg_ff, rsp_asg_in;
   logic [63:0]      rsp_nonce_ff, rsp_nonce_in;
   logic [63:0]      rsp_data_ff, rsp_data_in;
   logic [5:0]       rsp_idx_ff, rsp_idx_in;
   logic [9:0]       rsp_cnt_ff, rsp_cnt_in;
   logic             rsp_last_ff, rsp_last_in;

   // Memory ports.
   logic             ram_re, ram_we;
   logic [AW-1:0]    ram_raddr;
   logic [63:0]      ram_rd_data, ram_wr_data;

   // Decode of the held report.
   logic [63:0]      req_words [8];
   logic [31:0]      cid;
   logic [7:0]       b4;
   logic [15:0]      bcnt;
   logic [5:0]       init_chunk;
   logic [63:0]      nonce;
   logic [31:0]      granted;
   logic [LEN_W-1:0] remaining;
   logic [5:0]       cont_chunk;
   logic [LEN_W-1:0] new_recv;
   logic             slot_free;

   // Start of a fragment write.
   logic             w_go, w_done;
   logic [LEN_W-1:0] w_off, w_stop, w_last;
   logic [5:0]       w_chunk;
   logic [2:0]       w_base;

   logic [LEN_W-1:0] exp_m1;
   logic [AW-1:0]    rd_last;
   logic [5:0]       ping_m1;
   logic [2:0]       ping_last;
   logic [5:0]       ping_pos [8];
   logic [5:0]       ping_src [8];
   logic [63:0]      ping_word;
   logic [63:0]      read_word;
   logic             rd_load, rd_start;

   assign req_words[0] = req_report_word_0;
   assign req_words[1] = req_report_word_1;
   assign req_words[2] = req_report_word_2;
   assign req_words[3] = req_report_word_3;
   assign req_words[4] = req_report_word_4;
   assign req_words[5] = req_report_word_5;
   assign req_words[6] = req_report_word_6;
   assign req_words[7] = req_report_word_7;

   assign cid        = {rep_ff[0], rep_ff[1], rep_ff[2], rep_ff[3]};
   assign b4         = rep_ff[4];
   assign bcnt       = {rep_ff[5], rep_ff[6]};
   assign init_chunk = (bcnt < 16'(INIT_PAYLOAD)) ? bcnt[5:0] : INIT_PAYLOAD;
   assign nonce      = {rep_ff[7], rep_ff[8], rep_ff[9], rep_ff[10],
                        rep_ff[11], rep_ff[12], rep_ff[13], rep_ff[14]};
   assign granted    = (cid == BCAST_ID) ? next_ch_ff : cid;
   assign remaining  = exp_ff - recv_ff;
   assign cont_chunk = (remaining < LEN_W'(CONT_PAYLOAD)) ? remaining[5:0] : CONT_PAYLOAD;
   assign new_recv   = recv_ff + LEN_W'(cont_chunk);

   // The output register can take a new request result this cycle.
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   // Last readout word index; an empty message still reads one word.
   assign exp_m1  = exp_ff - LEN_W'(1);
   assign rd_last = (exp_ff == '0) ? '0 : exp_m1[AW+2:3];

   assign ping_m1   = ping_cnt_ff - 6'd1;
   assign ping_last = (ping_cnt_ff == '0) ? 3'd0 : ping_m1[5:3];

   assign w_stop = w_off + LEN_W'(w_chunk);
   assign w_last = w_stop - LEN_W'(1);

   // Echo and readout words, each byte past the length forced to zero.
   always_comb begin
      for (int j = 0; j < 8; j++) begin
         ping_pos[j] = {ping_k_ff, 3'(j)};
         ping_src[j] = ping_pos[j] + 6'(INIT_BASE);
         ping_word[63-8*j -: 8] = (ping_pos[j] < ping_cnt_ff) ? rep_ff[ping_src[j]] : 8'h00;
         read_word[63-8*j -: 8] = (LEN_W'({rd_cur_ff, 3'(j)}) < exp_ff) ?
                                  ram_rd_data[63-8*j -: 8] : 8'h00;
      end
   end

   // The readout loads a word once its read data is back and the output
   // register is free; the next read goes out in the same cycle.
   assign rd_load  = (state_ff == ST_READ) && rd_pend_ff && slot_free;
   assign rd_start = (state_ff == ST_READ) && rd_issue_ff && (!rd_pend_ff || rd_load);

   always_comb begin
      state_in      = state_ff;
      rep_in        = rep_ff;
      next_ch_in    = next_ch_ff;
      active_in     = active_ff;
      assembling_in = assembling_ff;
      asm_ch_in     = asm_ch_ff;
      exp_in        = exp_ff;
      recv_in       = recv_ff;
      seq_in        = seq_ff;
      win_in        = win_ff;
      wr_rd_in      = wr_rd_ff;
      wr_stop_in    = wr_stop_ff;
      wr_issue_in   = wr_issue_ff;
      pend_in       = pend_ff;
      pend_w_in     = pend_w_ff;
      done_read_in  = done_read_ff;
      rd_k_in       = rd_k_ff;
      rd_issue_in   = rd_issue_ff;
      rd_pend_in    = rd_pend_ff;
      rd_cur_in     = rd_cur_ff;
      ping_k_in     = ping_k_ff;
      ping_cnt_in   = ping_cnt_ff;

      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_kind_in   = rsp_kind_ff;
      rsp_ch_in     = rsp_ch_ff;
      rsp_asg_in    = rsp_asg_ff;
      rsp_nonce_in  = rsp_nonce_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      rsp_last_in   = rsp_last_ff;

      ram_re    = 1'b0;
      ram_we    = 1'b0;
      ram_raddr = (state_ff == ST_WRITE) ? wr_rd_ff : rd_k_ff;

      w_go    = 1'b0;
      w_done  = 1'b0;
      w_off   = '0;
      w_chunk = '0;
      w_base  = INIT_BASE;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               for (int i = 0; i < REPORT_BYTES; i++) begin
                  rep_in[i] = req_words[i/8][63-8*(i%8) -: 8];
               end
               state_in = ST_DECODE;
            end
         end

         ST_DECODE: begin
            if ((b4 & INIT_FLAG) != '0) begin
               if (b4 == CMD_INIT) begin
                  if (slot_free) begin
                     if (cid == BCAST_ID) begin
                        next_ch_in = next_ch_ff + 32'd1;
                     end
                     active_in     = granted;
                     assembling_in = 1'b0;
                     rsp_valid_in  = 1'b1;
                     rsp_kind_in   = KIND_INIT;
                     rsp_ch_in     = cid;
                     rsp_asg_in    = granted;
                     rsp_nonce_in  = nonce;
                     rsp_data_in   = '0;
                     rsp_idx_in    = '0;
                     rsp_cnt_in    = '0;
                     rsp_last_in   = 1'b1;
                     state_in      = ST_IDLE;
                  end
               end else if (cid != active_ff) begin
                  if (slot_free) begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = KIND_IGNORED;
                     rsp_ch_in    = cid;
                     rsp_asg_in   = '0;
                     rsp_nonce_in = '0;
                     rsp_data_in  = '0;
                     rsp_idx_in   = '0;
                     rsp_cnt_in   = '0;
                     rsp_last_in  = 1'b1;
                     state_in     = ST_IDLE;
                  end
               end else if (b4 == CMD_PING) begin
                  assembling_in = 1'b0;
                  ping_k_in     = '0;
                  ping_cnt_in   = init_chunk;
                  state_in      = ST_PING;
               end else if ((b4 != CMD_MSG) || (bcnt > MAX_LEN)) begin
                  if (slot_free) begin
                     assembling_in = 1'b0;
                     rsp_valid_in  = 1'b1;
                     rsp_kind_in   = KIND_INVALID;
                     rsp_ch_in     = cid;
                     rsp_asg_in    = '0;
                     rsp_nonce_in  = '0;
                     rsp_data_in   = '0;
                     rsp_idx_in    = '0;
                     rsp_cnt_in    = '0;
                     rsp_last_in   = 1'b1;
                     state_in      = ST_IDLE;
                  end
               end else begin
                  // A new message starts at offset zero.
                  asm_ch_in     = cid;
                  exp_in        = bcnt[LEN_W-1:0];
                  seq_in        = '0;
                  recv_in       = LEN_W'(init_chunk);
                  w_done        = (LEN_W'(init_chunk) >= bcnt[LEN_W-1:0]);
                  assembling_in = !w_done;
                  w_go          = 1'b1;
                  w_off         = '0;
                  w_chunk       = init_chunk;
                  w_base        = INIT_BASE;
               end
            end else if (!assembling_ff || (cid != asm_ch_ff) || (b4 != seq_ff)) begin
               // A continuation that does not belong to the open message.
               if (slot_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = KIND_IGNORED;
                  rsp_ch_in    = cid;
                  rsp_asg_in   = '0;
                  rsp_nonce_in = '0;
                  rsp_data_in  = '0;
                  rsp_idx_in   = '0;
                  rsp_cnt_in   = '0;
                  rsp_last_in  = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               recv_in       = new_recv;
               seq_in        = seq_ff + 8'd1;
               w_done        = (new_recv >= exp_ff);
               assembling_in = !w_done;
               w_go          = 1'b1;
               w_off         = recv_ff;
               w_chunk       = cont_chunk;
               w_base        = CONT_BASE;
            end

            if (w_go) begin
               win_in.start = w_off;
               win_in.stop  = w_stop;
               win_in.base  = w_base;
               wr_rd_in     = w_off[AW+2:3];
               wr_stop_in   = w_last[AW+2:3];
               wr_issue_in  = 1'b1;
               pend_in      = 1'b0;
               done_read_in = w_done;
               rd_k_in      = '0;
               rd_issue_in  = 1'b1;
               rd_pend_in   = 1'b0;
               if (w_chunk == '0) begin
                  state_in = w_done ? ST_READ : ST_FRAG;
               end else begin
                  state_in = ST_WRITE;
               end
            end
         end

         ST_PING: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_PING;
               rsp_ch_in    = cid;
               rsp_asg_in   = '0;
               rsp_nonce_in = '0;
               rsp_data_in  = ping_word;
               rsp_idx_in   = 6'(ping_k_ff);
               rsp_cnt_in   = 10'(ping_cnt_ff);
               rsp_last_in  = (ping_k_ff == ping_last);
               ping_k_in    = ping_k_ff + 3'd1;
               if (ping_k_ff == ping_last) begin
                  state_in = ST_IDLE;
               end
            end
         end

         ST_WRITE: begin
            // Read the next word while the word read last cycle is merged
            // and written back; the two addresses always differ.
            if (wr_issue_ff) begin
               ram_re    = 1'b1;
               pend_in   = 1'b1;
               pend_w_in = wr_rd_ff;
               if (wr_rd_ff == wr_stop_ff) begin
                  wr_issue_in = 1'b0;
               end else begin
                  wr_rd_in = wr_rd_ff + AW'(1);
               end
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff) begin
               ram_we = 1'b1;
               if (!wr_issue_ff) begin
                  state_in = done_read_ff ? ST_READ : ST_FRAG;
               end
            end
         end

         ST_FRAG: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_FRAG;
               rsp_ch_in    = cid;
               rsp_asg_in   = '0;
               rsp_nonce_in = '0;
               rsp_data_in  = '0;
               rsp_idx_in   = '0;
               rsp_cnt_in   = exp_ff;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         ST_READ: begin
            if (rd_start) begin
               ram_re     = 1'b1;
               rd_cur_in  = rd_k_ff;
               rd_pend_in = 1'b1;
               if (rd_k_ff == rd_last) begin
                  rd_issue_in = 1'b0;
               end else begin
                  rd_k_in = rd_k_ff + AW'(1);
               end
            end else if (rd_load) begin
               rd_pend_in = 1'b0;
            end
            if (rd_load) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_MESSAGE;
               rsp_ch_in    = cid;
               rsp_asg_in   = '0;
               rsp_nonce_in = '0;
               rsp_data_in  = read_word;
               rsp_idx_in   = 6'(rd_cur_ff);
               rsp_cnt_in   = exp_ff;
               rsp_last_in  = (rd_cur_ff == rd_last);
               if (rd_cur_ff == rd_last) begin
                  state_in = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rep_ff       <= rep_in;
      win_ff       <= win_in;
      wr_rd_ff     <= wr_rd_in;
      wr_stop_ff   <= wr_stop_in;
      pend_w_ff    <= pend_w_in;
      done_read_ff <= done_read_in;
      rd_k_ff      <= rd_k_in;
      rd_cur_ff    <= rd_cur_in;
      ping_k_ff    <= ping_k_in;
      ping_cnt_ff  <= ping_cnt_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_ch_ff    <= rsp_ch_in;
      rsp_asg_ff   <= rsp_asg_in;
      rsp_nonce_ff <= rsp_nonce_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_cnt_ff   <= rsp_cnt_in;
      rsp_last_ff  <= rsp_last_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         next_ch_ff    <= 32'd1;
         active_ff     <= '0;
         assembling_ff <= 1'b0;
         asm_ch_ff     <= '0;
         exp_ff        <= '0;
         recv_ff       <= '0;
         seq_ff        <= '0;
         wr_issue_ff   <= 1'b0;
         pend_ff       <= 1'b0;
         rd_issue_ff   <= 1'b0;
         rd_pend_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         next_ch_ff    <= next_ch_in;
         active_ff     <= active_in;
         assembling_ff <= assembling_in;
         asm_ch_ff     <= asm_ch_in;
         exp_ff        <= exp_in;
         recv_ff       <= recv_in;
         seq_ff        <= seq_in;
         wr_issue_ff   <= wr_issue_in;
         pend_ff       <= pend_in;
         rd_issue_ff   <= rd_issue_in;
         rd_pend_ff    <= rd_pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   ctrr_merge u_merge (
      .word_base (LEN_W'({pend_w_ff, 3'b000})),
      .win       (win_ff),
      .report    (rep_ff),
      .old_word  (ram_rd_data),
      .new_word  (ram_wr_data)
   );

   ctrr_ram #(
      .WIDTH (64),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (pend_w_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_channel_id  = rsp_ch_ff;
   assign rsp_assigned_id = rsp_asg_ff;
   assign rsp_nonce       = rsp_nonce_ff;
   assign rsp_data_word   = rsp_data_ff;
   assign rsp_word_index  = rsp_idx_ff;
   assign rsp_byte_count  = rsp_cnt_ff;
   assign rsp_last        = rsp_last_ff;

`ifndef SYNTH
   // The store is only written back by the fragment sequencer.
   a_write_in_frag: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_WRITE))
      else $error("message store written outside a fragment write");

   // The running length never passes the announced length.
   a_recv_bound: assert property (@(posedge clock) disable iff (reset)
      assembling_ff |-> (recv_ff < exp_ff))
      else $error("received length reached expected length while assembling");

   // A message word never starts at or past the message length, but for word zero.
   a_word_in_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_kind_ff == KIND_MESSAGE)) |->
      (({rsp_idx_ff, 3'b000} < rsp_cnt_ff) || (rsp_idx_ff == '0)))
      else $error("message word index beyond message length");

   // A taken request is always decoded in the following cycle.
   a_decode_next: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_DECODE))
      else $error("request taken but not decoded");
`endif

endmodule
